/* rtl/lpht_pkg.sv */
// ---------------------------------------------------------------------------
// Linear probe hash table: shared definitions
// Operation codes, result status codes, sizing defaults and the controller
// state type used by the table core.
// ---------------------------------------------------------------------------
package lpht_pkg;

   // Sizing defaults
   localparam int SLOT_COUNT_DEF  = 8;
   localparam int ENTRY_COUNT_DEF = 8;

   // Fixed field widths
   localparam int KIND_W   = 2;
   localparam int KEY_W    = 64;
   localparam int INDEX_W  = 3;
   localparam int STATUS_W = 2;

   // Entries reachable through the entry index field
   localparam int INDEX_SPAN = 1 << INDEX_W;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd3;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_ENTRY,
      ST_CMP,
      ST_RESP
   } state_type;

endpackage

/* rtl/lpht_ram.sv */
// ---------------------------------------------------------------------------
// Linear probe hash table: single-port RAM
// Generic synchronous RAM with one address port, write enable and a
// registered read.
// ---------------------------------------------------------------------------
module lpht_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 8,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read the addressed word every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/linear_probe_hash_table_core.sv */
// ---------------------------------------------------------------------------
// Linear probe hash table core
// Open-addressing hash table with linear probing over a power-of-two slot
// array. Slot contents and entry keys live in two single-port RAMs; slot
// occupancy and entry valid bits are held in flip-flops.
//
//   channel  direction  tdata / tuser                        meaning
//   req      in         tuser kind, tdata key + entry_index  insert/lookup/clear
//   rsp      out        tdata ok + status + found_index      one per request
//
// A request ends without probing on a clear, a zero-key lookup, a bad entry
// number on insert or an unused kind; otherwise it probes up to SLOT_COUNT
// slots, and each occupied slot probed costs a slot RAM read, a key RAM read
// and a compare. Reset empties every slot and clears every valid bit at
// once; the key RAM needs no clearing. A stalled response holds the
// controller until taken, and one request is in flight at a time.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_core #(
   parameter int SLOT_COUNT  = lpht_pkg::SLOT_COUNT_DEF,
   parameter int ENTRY_COUNT = lpht_pkg::ENTRY_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // key [63:0], entry_index [66:64], zero fill
   input  logic [1:0]  req_tuser,  // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // ok [0], status [2:1], found_index [5:3], zero fill
);

   localparam int SlotAw   = $clog2(SLOT_COUNT);
   localparam int KeyDepth = (ENTRY_COUNT < lpht_pkg::INDEX_SPAN) ?
                             ENTRY_COUNT : lpht_pkg::INDEX_SPAN;
   localparam int KeyAw    = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;
   localparam logic [SlotAw-1:0] LastProbe = SlotAw'(SLOT_COUNT - 1);

   // Request fields
   logic [lpht_pkg::KEY_W-1:0]   req_key;
   logic [lpht_pkg::INDEX_W-1:0] req_index;
   logic                         req_fire;
   logic                         req_in_range;
   logic                         req_key_zero;

   assign req_key      = req_tdata[63:0];
   assign req_index    = req_tdata[66:64];
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = 32'(req_index) < ENTRY_COUNT;
   assign req_key_zero = (req_key == '0);

   // Controller registers
   lpht_pkg::state_type state_ff, state_in;
   logic [lpht_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [lpht_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [KeyAw-1:0]              idx_ff, idx_in;
   logic [SlotAw-1:0]             slot_ff, slot_in;
   logic [SlotAw-1:0]             probe_ff, probe_in;
   logic [KeyAw-1:0]              ent_ff, ent_in;
   logic [SLOT_COUNT-1:0]         occ_ff, occ_in;
   logic [KeyDepth-1:0]           valid_ff, valid_in;
   logic                          res_ok_ff, res_ok_in;
   logic [lpht_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [lpht_pkg::INDEX_W-1:0]  res_found_ff, res_found_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                          slot_we;
   logic [KeyAw-1:0]              slot_rdata;
   logic                          key_we;
   logic [KeyAw-1:0]              key_addr;
   logic [lpht_pkg::KEY_W-1:0]    key_rdata;

   // Probe decisions
   logic is_insert;
   logic slot_empty;
   logic key_match;
   logic last_probe;
   logic rsp_free;

   assign is_insert  = (kind_ff == lpht_pkg::KIND_INSERT);
   assign slot_empty = !occ_ff[slot_ff];
   assign key_match  = (key_rdata == key_ff);
   assign last_probe = (probe_ff == LastProbe);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Slot array: entry number per slot
   lpht_ram #(
      .WIDTH (KeyAw),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .addr    (slot_ff),
      .wr_data (idx_ff),
      .rd_data (slot_rdata)
   );

   // Key store: written on insert accept, read at the probed entry
   lpht_ram #(
      .WIDTH (lpht_pkg::KEY_W),
      .DEPTH (KeyDepth)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .addr    (key_addr),
      .wr_data (req_key),
      .rd_data (key_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpht_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  lpht_pkg::KIND_INSERT: begin
                     state_in = req_in_range ? lpht_pkg::ST_SLOT : lpht_pkg::ST_RESP;
                  end
                  lpht_pkg::KIND_LOOKUP: begin
                     state_in = req_key_zero ? lpht_pkg::ST_RESP : lpht_pkg::ST_SLOT;
                  end
                  default: begin
                     state_in = lpht_pkg::ST_RESP;
                  end
               endcase
            end
         end
         lpht_pkg::ST_SLOT: begin
            state_in = slot_empty ? lpht_pkg::ST_RESP : lpht_pkg::ST_ENTRY;
         end
         lpht_pkg::ST_ENTRY: begin
            state_in = lpht_pkg::ST_CMP;
         end
         lpht_pkg::ST_CMP: begin
            if (key_match && (is_insert || valid_ff[ent_ff])) begin
               state_in = lpht_pkg::ST_RESP;
            end else if (last_probe) begin
               state_in = lpht_pkg::ST_RESP;
            end else begin
               state_in = lpht_pkg::ST_SLOT;
            end
         end
         lpht_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = lpht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpht_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      kind_in       = kind_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      ent_in        = ent_ff;
      occ_in        = occ_ff;
      valid_in      = valid_ff;
      res_ok_in     = res_ok_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      slot_we       = 1'b0;
      key_we        = 1'b0;
      key_addr      = idx_ff;
      req_tready    = 1'b0;

      unique case (state_ff)
         lpht_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            key_addr   = KeyAw'(req_index);
            if (req_fire) begin
               // Capture the request and start at the home slot
               kind_in       = req_tuser;
               key_in        = req_key;
               idx_in        = KeyAw'(req_index);
               slot_in       = req_key[SlotAw-1:0];
               probe_in      = '0;
               res_ok_in     = 1'b0;
               res_status_in = lpht_pkg::STATUS_MISS;
               res_found_in  = '0;
               unique case (req_tuser)
                  lpht_pkg::KIND_INSERT: begin
                     // Store the key before probing so a self-match counts
                     if (req_in_range) begin
                        key_we                       = 1'b1;
                        valid_in[KeyAw'(req_index)] = 1'b1;
                     end
                  end
                  lpht_pkg::KIND_LOOKUP: begin
                     if (req_key_zero) begin
                        res_status_in = lpht_pkg::STATUS_ZERO;
                     end
                  end
                  lpht_pkg::KIND_CLEAR: begin
                     occ_in        = '0;
                     valid_in      = '0;
                     res_ok_in     = 1'b1;
                     res_status_in = lpht_pkg::STATUS_OK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lpht_pkg::ST_SLOT: begin
            // Empty slot: claim it on insert, end the search on lookup
            if (slot_empty) begin
               if (is_insert) begin
                  slot_we         = 1'b1;
                  occ_in[slot_ff] = 1'b1;
                  res_ok_in       = 1'b1;
                  res_status_in   = lpht_pkg::STATUS_OK;
               end else begin
                  res_status_in   = lpht_pkg::STATUS_MISS;
               end
            end
         end
         lpht_pkg::ST_ENTRY: begin
            // Fetch the key of the entry held in the slot
            ent_in   = slot_rdata;
            key_addr = slot_rdata;
         end
         lpht_pkg::ST_CMP: begin
            if (is_insert && key_match) begin
               valid_in[idx_ff] = 1'b0;
               res_status_in    = lpht_pkg::STATUS_DUP;
            end else if (!is_insert && key_match && valid_ff[ent_ff]) begin
               res_ok_in     = 1'b1;
               res_status_in = lpht_pkg::STATUS_OK;
               res_found_in  = lpht_pkg::INDEX_W'(ent_ff);
            end else if (last_probe) begin
               if (is_insert) begin
                  valid_in[idx_ff] = 1'b0;
               end
               res_status_in = lpht_pkg::STATUS_MISS;
            end else begin
               // Advance to the next slot, wrapping round
               slot_in  = slot_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
            end
         end
         lpht_pkg::ST_RESP: begin
            // Hand the result over once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, res_found_ff, res_status_ff, res_ok_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::ST_IDLE;
         occ_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      probe_ff      <= probe_in;
      ent_ff        <= ent_in;
      res_ok_ff     <= res_ok_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // A new response only comes out of the response state
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == lpht_pkg::ST_RESP)
      else $error("response raised outside the response state");

   // A slot is only ever claimed while empty
   a_slot_claim_empty: assert property (@(posedge clock) disable iff (reset)
      slot_we |-> !occ_ff[slot_ff])
      else $error("occupied slot overwritten");

   // Clear empties every slot and valid bit
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == lpht_pkg::KIND_CLEAR) |=>
         (occ_ff == '0 && valid_ff == '0))
      else $error("clear left state behind");
`endif

endmodule

/* tb/sv/tb_linear_probe_hash_table_core.sv */
// ---------------------------------------------------------------------------
// Linear probe hash table core testbench
// Drives insert, lookup, clear and unused-kind requests into the table core
// and predicts every response from a private copy of the slot array, the key
// store and the entry valid bits. Each response is checked field by field
// against the oldest outstanding prediction. A directed pass covers zero
// keys, collisions, wrap-round, duplicates and a full table. Random phases
// then mix the request and response idling, including a long response
// hold-off and a drain between phases.
// ---------------------------------------------------------------------------
module tb_linear_probe_hash_table_core;
   import lpht_pkg::*;

   localparam int SLOT_N      = SLOT_COUNT_DEF;
   localparam int ENTRY_N     = ENTRY_COUNT_DEF;
   localparam int SETTLE_CYC  = 3 * SLOT_N + 6;
   localparam int HOLD_CYC    = 300;
   localparam int STUCK_LIMIT = 2000;
   localparam int POOL_N      = 12;
   localparam int PHASE_ITEMS = 125;

   // The one kind code the package leaves unnamed
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic                ok;
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  found_index;
   } reply_t;

   // Shadow of the hash table, predicting one reply per request
   class table_scoreboard;
      bit                 slot_used [SLOT_N];
      logic [INDEX_W-1:0] slot_entry [SLOT_N];
      logic [KEY_W-1:0]   entry_key [ENTRY_N];
      bit                 entry_live [ENTRY_N];
      reply_t             pending_replies [$];
      int unsigned        errors;

      function new();
         errors = 0;
         wipe();
      endfunction

      function void wipe();
         for (int s = 0; s < SLOT_N; s++) begin
            slot_used[s]  = 1'b0;
            slot_entry[s] = '0;
         end
         for (int e = 0; e < ENTRY_N; e++) begin
            entry_key[e]  = '0;
            entry_live[e] = 1'b0;
         end
      endfunction

      function int home_slot(logic [KEY_W-1:0] key, int probe);
         return (int'(key % SLOT_N) + probe) % SLOT_N;
      endfunction

      function logic [STATUS_W-1:0] insert_key(logic [KEY_W-1:0] key,
                                               logic [INDEX_W-1:0] idx);
         int s;
         int e;
         if (int'(idx) >= ENTRY_N)
            return STATUS_MISS;
         entry_key[idx]  = key;
         entry_live[idx] = 1'b1;
         for (int p = 0; p < SLOT_N; p++) begin
            s = home_slot(key, p);
            if (!slot_used[s]) begin
               slot_used[s]  = 1'b1;
               slot_entry[s] = idx;
               return STATUS_OK;
            end
            e = int'(slot_entry[s]);
            // a matching stored key stops the probe, whatever its valid bit
            if (e < ENTRY_N && entry_key[e] == key) begin
               entry_live[idx] = 1'b0;
               return STATUS_DUP;
            end
         end
         entry_live[idx] = 1'b0;
         return STATUS_MISS;
      endfunction

      function logic [STATUS_W-1:0] find_key(logic [KEY_W-1:0] key,
                                             output logic [INDEX_W-1:0] found);
         int s;
         int e;
         found = '0;
         if (key == '0)
            return STATUS_ZERO;
         for (int p = 0; p < SLOT_N; p++) begin
            s = home_slot(key, p);
            if (!slot_used[s])
               return STATUS_MISS;
            e = int'(slot_entry[s]);
            if (e < ENTRY_N && entry_live[e] && entry_key[e] == key) begin
               found = slot_entry[s];
               return STATUS_OK;
            end
         end
         return STATUS_MISS;
      endfunction

      function reply_t run_table_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                    logic [INDEX_W-1:0] idx);
         reply_t r;
         r = '{ok: 1'b0, status: STATUS_MISS, found_index: '0};
         case (kind)
            KIND_INSERT: r.status = insert_key(key, idx);
            KIND_LOOKUP: r.status = find_key(key, r.found_index);
            KIND_CLEAR: begin
               wipe();
               r.status = STATUS_OK;
            end
            default: r.status = STATUS_MISS;
         endcase
         r.ok = (kind != KIND_UNUSED) && (r.status == STATUS_OK);
         return r;
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                 logic [INDEX_W-1:0] idx);
         pending_replies.push_back(run_table_op(kind, key, idx));
      endfunction

      function void check_reply(logic [7:0] data);
         reply_t want;
         reply_t got;
         got = '{ok: data[0], status: data[2:1], found_index: data[5:3]};
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response, expected none, got ok %0d status %0d index %0d",
                     $time, got.ok, got.status, got.found_index);
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.ok !== want.ok) begin
            $display("%0t: ok mismatch, expected %0d, got %0d", $time, want.ok, got.ok);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            errors++;
         end
         if (got.found_index !== want.found_index) begin
            $display("%0t: found_index mismatch, expected %0d, got %0d",
                     $time, want.found_index, got.found_index);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // key [63:0], entry_index [66:64], zero fill
   logic [1:0]  req_tuser = '0;  // kind [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // ok [0], status [2:1], found_index [5:3], zero fill

   table_scoreboard  sb;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   logic             hold_request = 1'b0;
   int               hold_left = 0;
   int               stuck_cycles = 0;
   logic [KEY_W-1:0] key_pool [POOL_N];

   linear_probe_hash_table_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drive response ready: a long hold-off on request, else random stalls
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request <= 1'b0;
         hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_reply(rsp_tdata);
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Offer one request, idling first at random, and note it once taken
   task automatic send_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [INDEX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, idx, key};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, key, idx);
   endtask

   // Hold the request side until every predicted response has come back
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (sb.pending_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic pick_key(output logic [KEY_W-1:0] key);
      int r;
      r = $urandom_range(99);
      if (r < 80)
         key = key_pool[$urandom_range(POOL_N - 1)];
      else if (r < 92)
         key = {$urandom, $urandom};
      else
         key = '0;
   endtask

   // Mostly inserts and lookups over a small key pool, so that collisions,
   // duplicates and hits are common; clears keep the table from saturating
   task automatic send_random_request();
      logic [KEY_W-1:0]   key;
      logic [INDEX_W-1:0] idx;
      int                 r;
      pick_key(key);
      idx = INDEX_W'($urandom_range(INDEX_SPAN - 1));
      r = $urandom_range(99);
      if (r < 4)
         send_request(KIND_CLEAR, key, idx);
      else if (r < 7)
         send_request(KIND_UNUSED, {$urandom, $urandom}, idx);
      else if (r < 47)
         send_request(KIND_INSERT, key, idx);
      else
         send_request(KIND_LOOKUP, key, idx);
   endtask

   task automatic send_directed();
      send_request(KIND_CLEAR, '0, '0);
      send_request(KIND_LOOKUP, '0, '0);
      send_request(KIND_LOOKUP, 64'd5, '0);
      // zero key may be inserted but a lookup of it never finds it
      send_request(KIND_INSERT, '0, 3'd0);
      send_request(KIND_INSERT, '1, 3'd7);
      send_request(KIND_LOOKUP, '1, '0);
      send_request(KIND_INSERT, '1, 3'd3);
      send_request(KIND_LOOKUP, '1, '0);
      send_request(KIND_LOOKUP, '0, '0);
      send_request(KIND_UNUSED, '1, 3'd7);
      // collision on slot zero, then probe past it
      send_request(KIND_INSERT, 64'h8, 3'd1);
      send_request(KIND_LOOKUP, 64'h8, '0);
      send_request(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 3'd5);
      send_request(KIND_INSERT, 64'h5555_5555_5555_5555, 3'd6);
      send_request(KIND_LOOKUP, 64'h5555_5555_5555_5555, '0);
      // fill every slot with one reused entry, then hit the full table
      send_request(KIND_CLEAR, '0, '0);
      for (int k = 1; k <= SLOT_N; k++)
         send_request(KIND_INSERT, KEY_W'(k), 3'd0);
      send_request(KIND_INSERT, 64'd9, 3'd1);
      send_request(KIND_LOOKUP, 64'd8, '0);
      send_request(KIND_LOOKUP, 64'd3, '0);
      send_request(KIND_CLEAR, '0, '0);
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      drain_replies();

      // Phases: no idling, sender idle, receiver stalling, both, no idling
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
            3:       begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         for (int k = 0; k < POOL_N; k++)
            key_pool[k] = {$urandom, $urandom};
         // long response hold-off while requests keep coming
         if (phase == 0 || phase == 4)
            hold_request <= 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random_request();
         drain_replies();
      end

      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table_core.sv
tb/sv/tb_linear_probe_hash_table_core.sv
